[src/double_ended_queue_top_defines.svh]
// Assertion macros shared by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dq_pkg.sv]
// Package with the field widths, action codes and status codes of the deque.
`default_nettype none

package dq_pkg;

  // Field widths of the item and result channels.
  localparam int ACT_W = 3;
  localparam int DW    = 32;
  localparam int ST_W  = 2;
  localparam int OCC_W = 11;

  // Default number of words the queue can hold.
  localparam int DEPTH_DEF = 1024;

  // Actions carried by an input item.
  typedef enum logic [ACT_W-1:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4,
    ACT_CLEAR      = 3'd5
  } action_t;

  // Status reported with each result.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

[src/dq_store.sv]
// Word store of the deque: one write port and two registered read ports.
`default_nettype none

module dq_store #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [dq_pkg::DW-1:0]   wdata,
  input  wire logic [AW-1:0]           raddr_a,
  input  wire logic [AW-1:0]           raddr_b,
  output logic      [dq_pkg::DW-1:0]   rdata_a,
  output logic      [dq_pkg::DW-1:0]   rdata_b
);
  import dq_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_a_r;
  logic [DW-1:0] rd_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; a word written in the same cycle is passed straight through.
  always_ff @(posedge clk) begin
    if (en) begin
      rd_a_r <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
      rd_b_r <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

`default_nettype wire

[src/double_ended_queue_top.sv]
// Top level of the double-ended queue: item register, update logic and result register.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_action, in_value
//   out_    | output    | out_valid / out_ready | out_popped_value, out_status,
//           |           |                       | out_front_value, out_back_value,
//           |           |                       | out_occupancy, out_is_empty
//
// One item per cycle is sustained while out_ready is high; an accepted item is held
// in the item register and its result goes to the result register when it advances.
// The front and back words are kept in registers; the memory's two read ports
// fetch the words next to them for the following item, so one pass suffices.
// Reset clears the pointers and the count; the memory is not cleared.
// When a result stalls, one more item is held in the item register before
// in_ready drops.
`default_nettype none

module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic        [dq_pkg::ACT_W-1:0] in_action,
  input  wire logic signed [dq_pkg::DW-1:0]    in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [dq_pkg::DW-1:0]    out_popped_value,
  output logic             [dq_pkg::ST_W-1:0]  out_status,
  output logic signed      [dq_pkg::DW-1:0]    out_front_value,
  output logic signed      [dq_pkg::DW-1:0]    out_back_value,
  output logic             [dq_pkg::OCC_W-1:0] out_occupancy,
  output logic                               out_is_empty
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // Circular index step forward and backward.
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
    return (idx == '0) ? LAST_IDX : idx - AW'(1);
  endfunction

  // Item register.
  logic                 in_vld_r;
  logic [ACT_W-1:0]     act_r;
  logic signed [DW-1:0] val_r;

  // Queue state; last_r always equals head_r + cnt_r - 1 around the ring.
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] front_r, front_nxt;
  logic [DW-1:0] back_r, back_nxt;

  // Result register.
  logic                 out_vld_r;
  logic [DW-1:0]        popped_r;
  status_t              status_r;
  logic [DW-1:0]        front_out_r;
  logic [DW-1:0]        back_out_r;
  logic [OCC_W-1:0]     occ_r;
  logic                 empty_out_r;

  // Memory interface.
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic [DW-1:0] next_front_q;
  logic [DW-1:0] next_back_q;

  logic          advance;
  logic          q_full;
  logic          q_empty;
  logic [DW-1:0] popped;
  status_t       status;

  // The item in the register moves on when the result register is free.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action;
      val_r <= in_value;
    end
  end

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);

  // Apply the action to the pointers, count, end words, popped word, status and write.
  always_comb begin
    head_nxt  = head_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    popped    = '0;
    status    = ST_OK;
    we        = 1'b0;
    waddr     = idx_inc(last_r);
    case (act_r)
      ACT_PUSH_FRONT: begin
        if (q_full) begin
          status = ST_FULL;
        end else begin
          head_nxt  = idx_dec(head_r);
          we        = advance;
          waddr     = idx_dec(head_r);
          cnt_nxt   = cnt_r + CW'(1);
          front_nxt = val_r;
          if (q_empty) begin
            back_nxt = val_r;
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (q_full) begin
          status = ST_FULL;
        end else begin
          last_nxt = idx_inc(last_r);
          we       = advance;
          waddr    = idx_inc(last_r);
          cnt_nxt  = cnt_r + CW'(1);
          back_nxt = val_r;
          if (q_empty) begin
            front_nxt = val_r;
          end
        end
      end
      ACT_POP_FRONT: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          popped    = front_r;
          head_nxt  = idx_inc(head_r);
          cnt_nxt   = cnt_r - CW'(1);
          front_nxt = next_front_q;
        end
      end
      ACT_POP_BACK: begin
        if (q_empty) begin
          status = ST_EMPTY;
        end else begin
          popped   = back_r;
          last_nxt = idx_dec(last_r);
          cnt_nxt  = cnt_r - CW'(1);
          back_nxt = next_back_q;
        end
      end
      ACT_CLEAR: begin
        head_nxt = '0;
        last_nxt = LAST_IDX;
        cnt_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // Fetch the words next to the new ends for the following item.
  assign raddr_a = idx_inc(head_nxt);
  assign raddr_b = idx_dec(last_nxt);

  dq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dq_store (
    .clk     (clk),
    .en      (advance),
    .we      (we),
    .waddr   (waddr),
    .wdata   (val_r),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (next_front_q),
    .rdata_b (next_back_q)
  );

  // Queue state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      last_r <= LAST_IDX;
      cnt_r  <= '0;
    end else if (advance) begin
      head_r <= head_nxt;
      last_r <= last_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      popped_r    <= popped;
      status_r    <= status;
      front_out_r <= (cnt_nxt == '0) ? '0 : front_nxt;
      back_out_r  <= (cnt_nxt == '0) ? '0 : back_nxt;
      occ_r       <= OCC_W'(cnt_nxt);
      empty_out_r <= (cnt_nxt == '0);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_front_value  = front_out_r;
  assign out_back_value   = back_out_r;
  assign out_occupancy    = occ_r;
  assign out_is_empty     = empty_out_r;

endmodule

`default_nettype wire

[src/dq_checker.sv]
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none

`include "double_ended_queue_top_defines.svh"

module dq_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic signed [dq_pkg::DW-1:0]    out_popped_value,
  input wire logic        [dq_pkg::ST_W-1:0]  out_status,
  input wire logic        [dq_pkg::OCC_W-1:0] out_occupancy,
  input wire logic                            out_is_empty
);
  import dq_pkg::*;

  logic             out_acc;
  logic [OCC_W-1:0] prev_occ_r;

  assign out_acc = out_valid && out_ready;

  // Occupancy of the last delivered result, which is the state the next item sees.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_occ_r <= '0;
    end else if (out_acc) begin
      prev_occ_r <= out_occupancy;
    end
  end

  // A stalled result stays valid and keeps its popped value, status and occupancy.
  `DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_popped_value) && $stable(out_status) && $stable(out_occupancy), "stalled result changed")

  // A pop on an empty queue leaves it empty and returns zero.
  `DQ_ASSERT_NOW(a_empty_pop, out_acc && (out_status == ST_EMPTY), (prev_occ_r == '0) && (out_occupancy == '0) && out_is_empty && (out_popped_value == '0), "bad empty pop result")

  // A refused push leaves the count unchanged.
  `DQ_ASSERT_NOW(a_full_push, out_acc && (out_status == ST_FULL), (out_occupancy == prev_occ_r) && !out_is_empty, "bad full push result")

  // The count moves by at most one per item, except for a clear.
  `DQ_ASSERT_NOW(a_occ_step, out_acc, (out_occupancy == prev_occ_r) || (out_occupancy == prev_occ_r + OCC_W'(1)) || (out_occupancy == prev_occ_r - OCC_W'(1)) || (out_occupancy == '0), "occupancy jumped")

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_popped_value (out_popped_value),
  .out_status       (out_status),
  .out_occupancy    (out_occupancy),
  .out_is_empty     (out_is_empty)
);

`default_nettype wire
